@@ rtl/hpack_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HPACK Huffman decoder package
// Word types, node layout of the decode store and the fixed code table.
// ----------------------------------------------------------------------------
package hpack_pkg;

    localparam int HP_SYMS  = 257;
    localparam int HP_NODES = 513;
    localparam logic [8:0] HP_EOS = 9'd256;
    localparam logic [4:0] HP_MAX_PAD = 5'd7;

    localparam logic [1:0] HP_STAT_SYMBOL = 2'd0;
    localparam logic [1:0] HP_STAT_OK     = 2'd1;
    localparam logic [1:0] HP_STAT_BAD    = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } hp_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] status;
        logic       end_of_run;
    } hp_out_t;

    // child index (0 = absent) and child leaf tag (0 = internal, else symbol + 1)
    typedef struct packed {
        logic [9:0] c1;
        logic [8:0] t1;
        logic [9:0] c0;
        logic [8:0] t0;
    } hp_node_t;

    // {length, code} per symbol
    localparam logic [34:0] HP_TABLE [HP_SYMS] = '{
        {5'd13,30'h1ff8}, {5'd23,30'h7fffd8}, {5'd28,30'hfffffe2}, {5'd28,30'hfffffe3},
        {5'd28,30'hfffffe4}, {5'd28,30'hfffffe5}, {5'd28,30'hfffffe6}, {5'd28,30'hfffffe7},
        {5'd28,30'hfffffe8}, {5'd24,30'hffffea}, {5'd30,30'h3ffffffc}, {5'd28,30'hfffffe9},
        {5'd28,30'hfffffea}, {5'd30,30'h3ffffffd}, {5'd28,30'hfffffeb}, {5'd28,30'hfffffec},
        {5'd28,30'hfffffed}, {5'd28,30'hfffffee}, {5'd28,30'hfffffef}, {5'd28,30'hffffff0},
        {5'd28,30'hffffff1}, {5'd28,30'hffffff2}, {5'd30,30'h3ffffffe}, {5'd28,30'hffffff3},
        {5'd28,30'hffffff4}, {5'd28,30'hffffff5}, {5'd28,30'hffffff6}, {5'd28,30'hffffff7},
        {5'd28,30'hffffff8}, {5'd28,30'hffffff9}, {5'd28,30'hffffffa}, {5'd28,30'hffffffb},
        {5'd6,30'h14}, {5'd10,30'h3f8}, {5'd10,30'h3f9}, {5'd12,30'hffa},
        {5'd13,30'h1ff9}, {5'd6,30'h15}, {5'd8,30'hf8}, {5'd11,30'h7fa},
        {5'd10,30'h3fa}, {5'd10,30'h3fb}, {5'd8,30'hf9}, {5'd11,30'h7fb},
        {5'd8,30'hfa}, {5'd6,30'h16}, {5'd6,30'h17}, {5'd6,30'h18},
        {5'd5,30'h0}, {5'd5,30'h1}, {5'd5,30'h2}, {5'd6,30'h19},
        {5'd6,30'h1a}, {5'd6,30'h1b}, {5'd6,30'h1c}, {5'd6,30'h1d},
        {5'd6,30'h1e}, {5'd6,30'h1f}, {5'd7,30'h5c}, {5'd8,30'hfb},
        {5'd15,30'h7ffc}, {5'd6,30'h20}, {5'd12,30'hffb}, {5'd10,30'h3fc},
        {5'd13,30'h1ffa}, {5'd6,30'h21}, {5'd7,30'h5d}, {5'd7,30'h5e},
        {5'd7,30'h5f}, {5'd7,30'h60}, {5'd7,30'h61}, {5'd7,30'h62},
        {5'd7,30'h63}, {5'd7,30'h64}, {5'd7,30'h65}, {5'd7,30'h66},
        {5'd7,30'h67}, {5'd7,30'h68}, {5'd7,30'h69}, {5'd7,30'h6a},
        {5'd7,30'h6b}, {5'd7,30'h6c}, {5'd7,30'h6d}, {5'd7,30'h6e},
        {5'd7,30'h6f}, {5'd7,30'h70}, {5'd7,30'h71}, {5'd7,30'h72},
        {5'd8,30'hfc}, {5'd7,30'h73}, {5'd8,30'hfd}, {5'd13,30'h1ffb},
        {5'd19,30'h7fff0}, {5'd13,30'h1ffc}, {5'd14,30'h3ffc}, {5'd6,30'h22},
        {5'd15,30'h7ffd}, {5'd5,30'h3}, {5'd6,30'h23}, {5'd5,30'h4},
        {5'd6,30'h24}, {5'd5,30'h5}, {5'd6,30'h25}, {5'd6,30'h26},
        {5'd6,30'h27}, {5'd5,30'h6}, {5'd7,30'h74}, {5'd7,30'h75},
        {5'd6,30'h28}, {5'd6,30'h29}, {5'd6,30'h2a}, {5'd5,30'h7},
        {5'd6,30'h2b}, {5'd7,30'h76}, {5'd6,30'h2c}, {5'd5,30'h8},
        {5'd5,30'h9}, {5'd6,30'h2d}, {5'd7,30'h77}, {5'd7,30'h78},
        {5'd7,30'h79}, {5'd7,30'h7a}, {5'd7,30'h7b}, {5'd15,30'h7ffe},
        {5'd11,30'h7fc}, {5'd14,30'h3ffd}, {5'd13,30'h1ffd}, {5'd28,30'hffffffc},
        {5'd20,30'hfffe6}, {5'd22,30'h3fffd2}, {5'd20,30'hfffe7}, {5'd20,30'hfffe8},
        {5'd22,30'h3fffd3}, {5'd22,30'h3fffd4}, {5'd22,30'h3fffd5}, {5'd23,30'h7fffd9},
        {5'd22,30'h3fffd6}, {5'd23,30'h7fffda}, {5'd23,30'h7fffdb}, {5'd23,30'h7fffdc},
        {5'd23,30'h7fffdd}, {5'd23,30'h7fffde}, {5'd24,30'hffffeb}, {5'd23,30'h7fffdf},
        {5'd24,30'hffffec}, {5'd24,30'hffffed}, {5'd22,30'h3fffd7}, {5'd23,30'h7fffe0},
        {5'd24,30'hffffee}, {5'd23,30'h7fffe1}, {5'd23,30'h7fffe2}, {5'd23,30'h7fffe3},
        {5'd23,30'h7fffe4}, {5'd21,30'h1fffdc}, {5'd22,30'h3fffd8}, {5'd23,30'h7fffe5},
        {5'd22,30'h3fffd9}, {5'd23,30'h7fffe6}, {5'd23,30'h7fffe7}, {5'd24,30'hffffef},
        {5'd22,30'h3fffda}, {5'd21,30'h1fffdd}, {5'd20,30'hfffe9}, {5'd22,30'h3fffdb},
        {5'd22,30'h3fffdc}, {5'd23,30'h7fffe8}, {5'd23,30'h7fffe9}, {5'd21,30'h1fffde},
        {5'd23,30'h7fffea}, {5'd22,30'h3fffdd}, {5'd22,30'h3fffde}, {5'd24,30'hfffff0},
        {5'd21,30'h1fffdf}, {5'd22,30'h3fffdf}, {5'd23,30'h7fffeb}, {5'd23,30'h7fffec},
        {5'd21,30'h1fffe0}, {5'd21,30'h1fffe1}, {5'd22,30'h3fffe0}, {5'd21,30'h1fffe2},
        {5'd23,30'h7fffed}, {5'd22,30'h3fffe1}, {5'd23,30'h7fffee}, {5'd23,30'h7fffef},
        {5'd20,30'hfffea}, {5'd22,30'h3fffe2}, {5'd22,30'h3fffe3}, {5'd22,30'h3fffe4},
        {5'd23,30'h7ffff0}, {5'd22,30'h3fffe5}, {5'd22,30'h3fffe6}, {5'd23,30'h7ffff1},
        {5'd26,30'h3ffffe0}, {5'd26,30'h3ffffe1}, {5'd20,30'hfffeb}, {5'd19,30'h7fff1},
        {5'd22,30'h3fffe7}, {5'd23,30'h7ffff2}, {5'd22,30'h3fffe8}, {5'd25,30'h1ffffec},
        {5'd26,30'h3ffffe2}, {5'd26,30'h3ffffe3}, {5'd26,30'h3ffffe4}, {5'd27,30'h7ffffde},
        {5'd27,30'h7ffffdf}, {5'd26,30'h3ffffe5}, {5'd24,30'hfffff1}, {5'd25,30'h1ffffed},
        {5'd19,30'h7fff2}, {5'd21,30'h1fffe3}, {5'd26,30'h3ffffe6}, {5'd27,30'h7ffffe0},
        {5'd27,30'h7ffffe1}, {5'd26,30'h3ffffe7}, {5'd27,30'h7ffffe2}, {5'd24,30'hfffff2},
        {5'd21,30'h1fffe4}, {5'd21,30'h1fffe5}, {5'd26,30'h3ffffe8}, {5'd26,30'h3ffffe9},
        {5'd28,30'hffffffd}, {5'd27,30'h7ffffe3}, {5'd27,30'h7ffffe4}, {5'd27,30'h7ffffe5},
        {5'd20,30'hfffec}, {5'd24,30'hfffff3}, {5'd20,30'hfffed}, {5'd21,30'h1fffe6},
        {5'd22,30'h3fffe9}, {5'd21,30'h1fffe7}, {5'd21,30'h1fffe8}, {5'd23,30'h7ffff3},
        {5'd22,30'h3fffea}, {5'd22,30'h3fffeb}, {5'd25,30'h1ffffee}, {5'd25,30'h1ffffef},
        {5'd24,30'hfffff4}, {5'd24,30'hfffff5}, {5'd26,30'h3ffffea}, {5'd23,30'h7ffff4},
        {5'd26,30'h3ffffeb}, {5'd27,30'h7ffffe6}, {5'd26,30'h3ffffec}, {5'd26,30'h3ffffed},
        {5'd27,30'h7ffffe7}, {5'd27,30'h7ffffe8}, {5'd27,30'h7ffffe9}, {5'd27,30'h7ffffea},
        {5'd27,30'h7ffffeb}, {5'd28,30'hffffffe}, {5'd27,30'h7ffffec}, {5'd27,30'h7ffffed},
        {5'd27,30'h7ffffee}, {5'd27,30'h7ffffef}, {5'd27,30'h7fffff0}, {5'd26,30'h3ffffee},
        {5'd30,30'h3fffffff}
    };

endpackage
`default_nettype wire

@@ rtl/hpack_huffman_decoder_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HPACK Huffman decoder core
// Byte-in, symbol-out decoder walking the fixed code tree held in a RAM.
// ----------------------------------------------------------------------------
// After reset the core builds its decode tree in an internal 513-entry RAM by
// inserting all 257 codes, one tree step (a node read in ST_BRD, then ST_BEV)
// for each of the 4,688 code bits, with ST_BINIT clearing each of the 255 new
// internal nodes; no word is accepted until the build finishes. Then each
// input word is accepted in ST_IDLE and walked bit by bit in ST_BITS, which
// holds while a held symbol waits on a full output register; ST_FLUSH flushes
// the byte and, on a last byte, ST_STATUS sends the status word. No new word
// is accepted until the core is back in ST_IDLE, and a byte that hits an
// error leaves the bit walk early. The tree RAM read of the next node is
// issued in the same cycle as the current step. Each byte yields up to two
// symbol words (status 0), and the last byte of a string adds one status word
// (1 ok, 2 invalid); end_of_run marks the final word caused by each byte. A
// decoding error is sticky and silences the rest of the string.
module hpack_huffman_decoder_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire hpack_pkg::hp_in_t  in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output hpack_pkg::hp_out_t   out_data
);
    import hpack_pkg::*;

    typedef enum logic [8:0] {
        ST_ROOT   = 9'b000000001,
        ST_BRD    = 9'b000000010,
        ST_BEV    = 9'b000000100,
        ST_BINIT  = 9'b000001000,
        ST_BDONE  = 9'b000010000,
        ST_IDLE   = 9'b000100000,
        ST_BITS   = 9'b001000000,
        ST_FLUSH  = 9'b010000000,
        ST_STATUS = 9'b100000000
    } state_t;

    // decode tree RAM
    hp_node_t   mem [HP_NODES];
    hp_node_t   rdata_reg;
    logic       we;
    logic [9:0] wa;
    logic [9:0] ra;
    hp_node_t   wd;

    state_t     state_reg, state_next;
    // build sequencer
    logic [8:0] sym_reg, sym_next;
    logic [4:0] bidx_reg, bidx_next;
    logic [9:0] cur_reg, cur_next;
    logic [9:0] used_reg, used_next;
    // string state
    logic [9:0] pos_reg, pos_next;
    logic [4:0] pend_reg, pend_next;
    logic       ones_reg, ones_next;
    logic       fail_reg, fail_next;
    // current byte
    logic [7:0] byte_reg, byte_next;
    logic       lastb_reg, lastb_next;
    logic [2:0] cnt_reg, cnt_next;
    // held symbol, waiting to learn whether it ends the run
    logic       hold_valid_reg, hold_valid_next;
    logic [7:0] hold_reg, hold_next;
    // output register
    logic       out_valid_reg, out_valid_next;
    hp_out_t    out_reg, out_next;

    logic       push;
    hp_out_t    push_data;
    logic       can_push;

    logic [34:0] ent_cur;
    logic [34:0] ent_nxt;
    logic [8:0]  sym_inc;
    logic        bbit;
    logic [9:0]  bch;
    logic        dbit;
    logic [9:0]  dch;
    logic [8:0]  dtg;
    logic [8:0]  dsym;
    logic [1:0]  stat;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rdata_reg <= mem[ra];
    end

    assign can_push  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign sym_inc = sym_reg + 9'd1;
    assign ent_cur = HP_TABLE[sym_reg];
    assign ent_nxt = HP_TABLE[sym_inc];
    assign bbit    = ent_cur[bidx_reg];
    assign bch     = bbit ? rdata_reg.c1 : rdata_reg.c0;

    assign dbit = byte_reg[cnt_reg];
    assign dch  = dbit ? rdata_reg.c1 : rdata_reg.c0;
    assign dtg  = dbit ? rdata_reg.t1 : rdata_reg.t0;
    assign dsym = dtg - 9'd1;

    always_comb
    begin
        stat = HP_STAT_OK;
        if (fail_reg)
        begin
            stat = HP_STAT_BAD;
        end
        else if ((pos_reg != 10'd0) && ((pend_reg > HP_MAX_PAD) || !ones_reg))
        begin
            stat = HP_STAT_BAD;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        sym_next        = sym_reg;
        bidx_next       = bidx_reg;
        cur_next        = cur_reg;
        used_next       = used_reg;
        pos_next        = pos_reg;
        pend_next       = pend_reg;
        ones_next       = ones_reg;
        fail_next       = fail_reg;
        byte_next       = byte_reg;
        lastb_next      = lastb_reg;
        cnt_next        = cnt_reg;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        we              = 1'b0;
        wa              = cur_reg;
        wd              = '0;
        push            = 1'b0;
        push_data       = '0;

        unique case (state_reg)
            ST_ROOT:
            begin
                // clear the root entry and start with the first code
                we         = 1'b1;
                wa         = 10'd0;
                used_next  = 10'd1;
                cur_next   = 10'd0;
                sym_next   = 9'd0;
                bidx_next  = ent_cur[34:30] - 5'd1;
                state_next = ST_BRD;
            end
            ST_BRD:
            begin
                state_next = ST_BEV;
            end
            ST_BEV:
            begin
                if ((bch != 10'd0) && (bidx_reg != 5'd0))
                begin
                    cur_next   = bch;
                    bidx_next  = bidx_reg - 5'd1;
                    state_next = ST_BRD;
                end
                else
                begin
                    // attach a new child; a leaf carries its tag in the parent
                    we = 1'b1;
                    wd = rdata_reg;
                    if (bbit)
                    begin
                        wd.c1 = used_reg;
                        wd.t1 = (bidx_reg == 5'd0) ? sym_inc : 9'd0;
                    end
                    else
                    begin
                        wd.c0 = used_reg;
                        wd.t0 = (bidx_reg == 5'd0) ? sym_inc : 9'd0;
                    end
                    used_next = used_reg + 10'd1;
                    if (bidx_reg == 5'd0)
                    begin
                        if (sym_reg == HP_EOS)
                        begin
                            state_next = ST_BDONE;
                        end
                        else
                        begin
                            sym_next   = sym_inc;
                            cur_next   = 10'd0;
                            bidx_next  = ent_nxt[34:30] - 5'd1;
                            state_next = ST_BRD;
                        end
                    end
                    else
                    begin
                        cur_next   = used_reg;
                        state_next = ST_BINIT;
                    end
                end
            end
            ST_BINIT:
            begin
                we         = 1'b1;
                bidx_next  = bidx_reg - 5'd1;
                state_next = ST_BRD;
            end
            ST_BDONE:
            begin
                state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    byte_next  = in_data.data_byte;
                    lastb_next = in_data.last_byte;
                    cnt_next   = 3'd7;
                    state_next = ST_BITS;
                end
            end
            ST_BITS:
            begin
                if (fail_reg)
                begin
                    state_next = ST_FLUSH;
                end
                else if (dch == 10'd0)
                begin
                    fail_next  = 1'b1;
                    state_next = ST_FLUSH;
                end
                else if (dtg == (HP_EOS + 9'd1))
                begin
                    fail_next  = 1'b1;
                    state_next = ST_FLUSH;
                end
                else if (dtg != 9'd0)
                begin
                    // hold the step while a held symbol cannot move out
                    if (!hold_valid_reg || can_push)
                    begin
                        if (hold_valid_reg)
                        begin
                            push      = 1'b1;
                            push_data = '{out_byte: hold_reg, status: HP_STAT_SYMBOL,
                                          end_of_run: 1'b0};
                        end
                        hold_valid_next = 1'b1;
                        hold_next       = dsym[7:0];
                        pos_next        = 10'd0;
                        pend_next       = 5'd0;
                        ones_next       = 1'b1;
                        if (cnt_reg == 3'd0)
                        begin
                            state_next = ST_FLUSH;
                        end
                        else
                        begin
                            cnt_next = cnt_reg - 3'd1;
                        end
                    end
                end
                else
                begin
                    pos_next  = dch;
                    pend_next = (pend_reg == 5'd31) ? pend_reg : pend_reg + 5'd1;
                    ones_next = ones_reg & dbit;
                    if (cnt_reg == 3'd0)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        cnt_next = cnt_reg - 3'd1;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (hold_valid_reg)
                begin
                    if (can_push)
                    begin
                        push      = 1'b1;
                        push_data = '{out_byte: hold_reg, status: HP_STAT_SYMBOL,
                                      end_of_run: !lastb_reg};
                        hold_valid_next = 1'b0;
                        state_next = lastb_reg ? ST_STATUS : ST_IDLE;
                    end
                end
                else
                begin
                    state_next = lastb_reg ? ST_STATUS : ST_IDLE;
                end
            end
            ST_STATUS:
            begin
                if (can_push)
                begin
                    push      = 1'b1;
                    push_data = '{out_byte: 8'd0, status: stat, end_of_run: 1'b1};
                    pos_next   = 10'd0;
                    pend_next  = 5'd0;
                    ones_next  = 1'b1;
                    fail_next  = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_ROOT;
            end
        endcase
    end

    // read the node that the next cycle works on
    always_comb
    begin
        case (state_reg) inside
            ST_ROOT, ST_BEV, ST_BINIT: ra = cur_next;
            ST_BRD:                    ra = cur_reg;
            default:                   ra = pos_next;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (push)
        begin
            out_valid_next = 1'b1;
            out_next       = push_data;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_ROOT;
            sym_reg        <= '0;
            bidx_reg       <= '0;
            cur_reg        <= '0;
            used_reg       <= '0;
            pos_reg        <= '0;
            pend_reg       <= '0;
            ones_reg       <= 1'b1;
            fail_reg       <= 1'b0;
            cnt_reg        <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sym_reg        <= sym_next;
            bidx_reg       <= bidx_next;
            cur_reg        <= cur_next;
            used_reg       <= used_next;
            pos_reg        <= pos_next;
            pend_reg       <= pend_next;
            ones_reg       <= ones_next;
            fail_reg       <= fail_next;
            cnt_reg        <= cnt_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg  <= byte_next;
        lastb_reg <= lastb_next;
        hold_reg  <= hold_next;
        out_reg   <= out_next;
    end

endmodule
`default_nettype wire

@@ test/hpack_huffman_decoder_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HPACK Huffman decoder core testbench
// Drives encoded strings through the core and checks each decoded word
// against typed words or a local tree walker built from the package code table.
// ----------------------------------------------------------------------------
// Flow:
//   - wait for the core to finish building its tree (in_ready rises)
//   - directed table: padding extremes, EOS, bad padding, plain bytes
//   - random strings: mostly well-formed codes padded with ones, plus
//     broken strings (zero padding, EOS inside, overlong padding, noise)
//   - three idle profiles: light sender / heavy receiver, the reverse, none
module hpack_huffman_decoder_core_test;
    import hpack_pkg::*;

    localparam int LIMIT = 600000;
    localparam int DIRECTED_ROWS = 16;

    logic    clk;
    logic    rst_n;
    logic    in_valid;
    logic    in_ready;
    hp_in_t  in_data;
    logic    out_valid;
    logic    out_ready;
    hp_out_t out_data;

    // decode tree of our own, built from the package code table
    int kid [HP_NODES][2];
    int leaf [HP_NODES];

    // string state of the walker
    int  walk_node;
    int  walk_pend;
    bit  walk_ones;
    bit  walk_failed;

    hp_out_t decoded_words [$];   // words still owed by the core
    hp_out_t step_words [$];      // words produced by one byte

    int  errors;
    int  cycles;
    int  bytes_sent;
    int  words_seen;
    int  strings_sent;
    int  send_idle_pct;
    int  recv_idle_pct;

    typedef struct {
        logic [7:0] data;
        bit         last;
        int         n_typed;   // -1: take the walker's words
        hp_out_t    w0;
        hp_out_t    w1;
    } row_t;

    row_t rows [DIRECTED_ROWS];

    hpack_huffman_decoder_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("timeout at %0t", $time);
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic void build_tree();
        int used;
        int cur;
        int len;
        int b;
        logic [29:0] code;
        used = 1;
        for (int n = 0; n < HP_NODES; n++)
        begin
            kid[n][0] = 0;
            kid[n][1] = 0;
            leaf[n] = 0;
        end
        for (int s = 0; s < HP_SYMS; s++)
        begin
            len = int'(HP_TABLE[s][34:30]);
            code = HP_TABLE[s][29:0];
            cur = 0;
            for (int i = len - 1; i >= 0; i--)
            begin
                b = int'(code[i]);
                if (kid[cur][b] == 0)
                begin
                    kid[cur][b] = used;
                    used++;
                end
                cur = kid[cur][b];
            end
            leaf[cur] = s + 1;
        end
    endfunction

    function automatic void clear_walk();
        walk_node = 0;
        walk_pend = 0;
        walk_ones = 1'b1;
        walk_failed = 1'b0;
    endfunction

    // Walk one byte through the tree; leave its words in step_words.
    function automatic void decode_byte(logic [7:0] d, bit l);
        hp_out_t w;
        int nx;
        int sym;
        logic [1:0] st;
        step_words.delete();
        for (int j = 7; j >= 0; j--)
        begin
            if (walk_failed)
                break;
            nx = kid[walk_node][d[j]];
            if (nx == 0)
            begin
                walk_failed = 1'b1;
                break;
            end
            walk_node = nx;
            if (walk_pend < 31)
                walk_pend++;
            walk_ones &= d[j];
            if (leaf[nx] != 0)
            begin
                sym = leaf[nx] - 1;
                if (sym == int'(HP_EOS))
                begin
                    walk_failed = 1'b1;
                    break;
                end
                w.out_byte = sym[7:0];
                w.status = HP_STAT_SYMBOL;
                w.end_of_run = 1'b0;
                step_words = {step_words, w};
                walk_node = 0;
                walk_pend = 0;
                walk_ones = 1'b1;
            end
        end
        if (l)
        begin
            st = HP_STAT_OK;
            if (walk_failed)
                st = HP_STAT_BAD;
            else if (walk_node != 0 && (walk_pend > int'(HP_MAX_PAD) || !walk_ones))
                st = HP_STAT_BAD;
            w.out_byte = 8'd0;
            w.status = st;
            w.end_of_run = 1'b0;
            step_words = {step_words, w};
            clear_walk();
        end
        if (step_words.size() > 0)
            step_words[step_words.size() - 1].end_of_run = 1'b1;
    endfunction

    // Offer one word; on acceptance queue what it should produce.
    task automatic send_byte(logic [7:0] d, bit l, int n_typed, hp_out_t w0, hp_out_t w1);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data.data_byte <= d;
        in_data.last_byte <= l;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        decode_byte(d, l);
        if (n_typed < 0)
        begin
            foreach (step_words[k])
                decoded_words = {decoded_words, step_words[k]};
        end
        else
        begin
            if (n_typed > 0)
                decoded_words = {decoded_words, w0};
            if (n_typed > 1)
                decoded_words = {decoded_words, w1};
        end
        bytes_sent++;
        if (l)
            strings_sent++;
    endtask

    task automatic send_plain(logic [7:0] d, bit l);
        send_byte(d, l, -1, '0, '0);
    endtask

    task automatic go_idle();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Hold the sender until the core owes nothing, then let it drain.
    task automatic drain();
        go_idle();
        while (decoded_words.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Build one string and send it. kind 0 is well-formed; 1 zero padding;
    // 2 EOS inside; 3 an extra all-ones byte; 4 raw noise.
    task automatic send_string(int kind);
        bit bits [$];
        int nsyms;
        int s;
        int len;
        int pad;
        logic [7:0] d;
        logic [29:0] code;
        if (kind == 4)
        begin
            nsyms = $urandom_range(1, 4);
            for (int i = 0; i < nsyms; i++)
                send_plain(8'($urandom_range(255)), i == nsyms - 1);
            return;
        end
        nsyms = $urandom_range(1, 5);
        for (int i = 0; i < nsyms; i++)
        begin
            if ($urandom_range(3) == 0)
                s = $urandom_range(255);
            else
                s = $urandom_range(32, 126);
            if (kind == 2 && i == nsyms - 1)
                s = HP_SYMS - 1;
            len = int'(HP_TABLE[s][34:30]);
            code = HP_TABLE[s][29:0];
            for (int b = len - 1; b >= 0; b--)
                bits = {bits, code[b]};
        end
        pad = (8 - bits.size() % 8) % 8;
        for (int i = 0; i < pad; i++)
            bits = {bits, bit'(!(kind == 1 && i == 0))};
        if (kind == 3)
            for (int i = 0; i < 8; i++)
                bits = {bits, 1'b1};
        while (bits.size() > 0)
        begin
            for (int b = 7; b >= 0; b--)
                d[b] = bits.pop_front();
            send_plain(d, bits.size() == 0);
        end
    endtask

    task automatic random_phase(int count);
        int k;
        int target;
        target = bytes_sent + count;
        while (bytes_sent < target)
        begin
            k = $urandom_range(99);
            if (k < 75)
                send_string(0);
            else
                send_string(1 + (k % 4));
        end
    endtask

    // Receiver: stall at random and check every accepted word.
    always @(posedge clk or negedge rst_n)
    begin
        hp_out_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
            if (out_valid && out_ready)
            begin
                words_seen++;
                if (decoded_words.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected word expected none actual %h", $time,
                             out_data);
                end
                else
                begin
                    want = decoded_words.pop_front();
                    if (out_data.out_byte !== want.out_byte)
                    begin
                        errors++;
                        $display("%0t: out_byte expected %h actual %h", $time,
                                 want.out_byte, out_data.out_byte);
                    end
                    if (out_data.status !== want.status)
                    begin
                        errors++;
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want.status, out_data.status);
                    end
                    if (out_data.end_of_run !== want.end_of_run)
                    begin
                        errors++;
                        $display("%0t: end_of_run expected %b actual %b", $time,
                                 want.end_of_run, out_data.end_of_run);
                    end
                end
            end
        end
    end

    initial
    begin
        errors = 0;
        cycles = 0;
        bytes_sent = 0;
        words_seen = 0;
        strings_sent = 0;
        send_idle_pct = 11;
        recv_idle_pct = 56;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        build_tree();
        clear_walk();

        // typed rows: words readable straight from the code
        rows[0]  = '{8'hFF, 1, 1, '{8'h00, HP_STAT_BAD, 1'b1}, '0};      // 8 pad bits
        rows[1]  = '{8'h07, 1, 2, '{8'h30, HP_STAT_SYMBOL, 1'b0},
                     '{8'h00, HP_STAT_OK, 1'b1}};                        // '0' + ones pad
        rows[2]  = '{8'h00, 1, 2, '{8'h30, HP_STAT_SYMBOL, 1'b0},
                     '{8'h00, HP_STAT_BAD, 1'b1}};                       // zero padding
        rows[3]  = '{8'hFF, 0, 0, '0, '0};                               // EOS: 30 ones
        rows[4]  = '{8'hFF, 0, 0, '0, '0};
        rows[5]  = '{8'hFF, 0, 0, '0, '0};
        rows[6]  = '{8'hFF, 1, 1, '{8'h00, HP_STAT_BAD, 1'b1}, '0};
        // walker-checked rows
        rows[7]  = '{8'h00, 0, -1, '0, '0};
        rows[8]  = '{8'h00, 0, -1, '0, '0};
        rows[9]  = '{8'h07, 1, -1, '0, '0};
        rows[10] = '{8'h8C, 1, -1, '0, '0};
        rows[11] = '{8'hA5, 0, -1, '0, '0};
        rows[12] = '{8'h5A, 1, -1, '0, '0};
        rows[13] = '{8'hFE, 1, -1, '0, '0};
        rows[14] = '{8'h3F, 0, -1, '0, '0};
        rows[15] = '{8'h1F, 1, -1, '0, '0};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        // hold until the tree build finishes
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);

        foreach (rows[i])
            send_byte(rows[i].data, rows[i].last, rows[i].n_typed, rows[i].w0, rows[i].w1);
        drain();

        random_phase(115);
        drain();
        send_idle_pct = 56;
        recv_idle_pct = 11;
        random_phase(115);
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(115);
        drain();

        $display("covered %0d bytes in %0d strings, %0d decoded words checked",
                 bytes_sent, strings_sent, words_seen);
        $display("idle profiles: light/heavy, heavy/light, none");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/hpack_pkg.sv
rtl/hpack_huffman_decoder_core.sv
test/hpack_huffman_decoder_core_test.sv
